FILE: design/pixel_blend_mode_unit_defines.svh
// Assertion macros shared by the pixel blend mode unit modules.
`ifndef PIXEL_BLEND_MODE_UNIT_DEFINES_SVH
`define PIXEL_BLEND_MODE_UNIT_DEFINES_SVH

// A property that must hold at every rising clock edge outside reset.
`define BLM_CHECK(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// An implication that must hold at every rising clock edge outside reset.
`define BLM_CHECK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/blm_pkg.sv
// Shared types and constants of the pixel blend mode unit.
`timescale 1ns / 1ps
package blm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MODE_W        = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL        = 4'd0,
        MODE_MULTIPLY      = 4'd1,
        MODE_SCREEN        = 4'd2,
        MODE_OVERLAY       = 4'd3,
        MODE_OVERLAY_INV   = 4'd4,
        MODE_ADD           = 4'd5,
        MODE_GRAIN_EXTRACT = 4'd6,
        MODE_GRAIN_MERGE   = 4'd7,
        MODE_SUBTRACT      = 4'd8,
        MODE_DIFFERENCE    = 4'd9,
        MODE_DARKEN        = 4'd10,
        MODE_LIGHTEN       = 4'd11,
        MODE_DODGE         = 4'd12,
        MODE_BURN          = 4'd13
    } t_mode;

    // Which unit produces the final value of a transaction.
    typedef enum logic [1:0] {
        PATH_SIMPLE = 2'd0,
        PATH_MULT   = 2'd1,
        PATH_DIV    = 2'd2
    } t_path;

    typedef struct packed {
        logic  vld;
        logic  inv;
        logic  burn;
        t_path path;
    } t_ctl;

endpackage

FILE: design/pixel_blend_mode_unit.sv
// Top level of the pixel blend mode unit: mode register, pipeline and output stage.
`timescale 1ns / 1ps
`include "pixel_blend_mode_unit_defines.svh"
// The unit blends one base channel value with one layer channel value under the
// mode held in the mode register, in unsigned fixed point where 2^FRAC_BITS is 1.0.
// It takes a new transaction in every clock cycle outside reset and returns each
// result in order, one result per transaction, whatever the mode. The depth of the
// pipeline is set by the divider used for dodge and burn, which resolves one
// quotient bit per pipeline stage; every other mode travels alongside it so that
// results stay in order. The result appears on o_blended_value for a single cycle
// with o_strobe high and must be captured then, since the receiver cannot stall
// the unit. busy is high only while reset is held. Write the mode register only
// when no transaction is in flight; a transaction uses the mode that was in force
// when it was accepted.
module pixel_blend_mode_unit
    import blm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [MODE_W-1:0]   i_cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic [FRAC_BITS:0]  i_base_value,
    input  logic [FRAC_BITS:0]  i_blend_value,
    output logic                o_strobe,
    output logic [FRAC_BITS:0]  o_blended_value
);

    localparam int W      = FRAC_BITS + 1;
    localparam int SIDE_W = W + 2;
    // Input stage, prepare stage, multiply stage, divider (W + 1), output stage.
    localparam int LAT    = FRAC_BITS + 6;
    localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Mode register. Reset selects the normal mode, which passes the layer value.
    logic [MODE_W-1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // The pipeline never stalls, so a transaction is refused only during reset.
    logic accept;

    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    // Stages 1 and 2: saturate the inputs to one, then set up the operands of the
    // multiplier and divider and compute the modes that need only adds and compares.
    t_ctl         front_ctl;
    logic [W-1:0] front_x;
    logic [W-1:0] front_y;
    logic [W-1:0] front_s;
    logic [W-1:0] front_num;
    logic [W-1:0] front_den;

    blm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (accept),
        .i_mode   (r_mode),
        .i_base   (i_base_value),
        .i_blend  (i_blend_value),
        .o_ctl    (front_ctl),
        .o_x      (front_x),
        .o_y      (front_y),
        .o_simple (front_s),
        .o_num    (front_num),
        .o_den    (front_den)
    );

    // Stage 3: the product modes (multiply, screen, both overlays) finish here and
    // merge with the adder result, so a single value travels on from this point.
    t_ctl         mul_ctl;
    logic [W-1:0] mul_res;
    logic [W-1:0] mul_num;
    logic [W-1:0] mul_den;

    blm_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (front_ctl),
        .i_x      (front_x),
        .i_y      (front_y),
        .i_simple (front_s),
        .i_num    (front_num),
        .i_den    (front_den),
        .o_ctl    (mul_ctl),
        .o_res    (mul_res),
        .o_num    (mul_num),
        .o_den    (mul_den)
    );

    // Divider stages. Every transaction passes through them; the finished result of
    // non-divide modes and the path flags ride along as sideband.
    logic [SIDE_W-1:0] div_side_in;
    logic [SIDE_W-1:0] div_side_out;
    logic              div_vld;
    logic [W-1:0]      div_quo;
    logic              side_is_div;
    logic              side_burn;
    logic [W-1:0]      side_res;

    assign div_side_in = {(mul_ctl.path == PATH_DIV), mul_ctl.burn, mul_res};

    blm_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (mul_ctl.vld),
        .i_num   (mul_num),
        .i_den   (mul_den),
        .i_side  (div_side_in),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side_out)
    );

    assign side_is_div = div_side_out[W+1];
    assign side_burn   = div_side_out[W];
    assign side_res    = div_side_out[W-1:0];

    // Output stage. Burn reports one minus the clamped quotient, dodge the quotient.
    logic         r_out_vld;
    logic [W-1:0] r_out_val;
    logic [W-1:0] n_out_val;

    always_comb begin
        if (side_is_div) begin
            n_out_val = side_burn ? ONE - div_quo : div_quo;
        end else begin
            n_out_val = side_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val <= n_out_val;
    end

    assign o_strobe        = r_out_vld;
    assign o_blended_value = r_out_val;

    `BLM_CHECK(a_latency, i_clk, i_rst_n, o_strobe == $past(accept, LAT), "strobe mismatch")
    `BLM_CHECK_IMPL(a_out_range, i_clk, i_rst_n, o_strobe, o_blended_value <= ONE, "out of range")

endmodule

FILE: design/blm_front.sv
// Input saturation stage and operand preparation stage of the blend pipeline.
`timescale 1ns / 1ps
module blm_front
    import blm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [FRAC_BITS:0]  i_base,
    input  logic [FRAC_BITS:0]  i_blend,
    output t_ctl                o_ctl,
    output logic [FRAC_BITS:0]  o_x,
    output logic [FRAC_BITS:0]  o_y,
    output logic [FRAC_BITS:0]  o_simple,
    output logic [FRAC_BITS:0]  o_num,
    output logic [FRAC_BITS:0]  o_den
);

    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [W-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    function automatic logic [W-1:0] clamp_one(input logic [W:0] v);
        logic [W-1:0] r;
        r = (v > {1'b0, ONE}) ? ONE : v[W-1:0];
        return r;
    endfunction

    // Stage 1: saturated inputs and the mode in force for this transaction.
    logic              r_vld1;
    logic [W-1:0]      r_a;
    logic [W-1:0]      r_b;
    logic [MODE_W-1:0] r_mode1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= (i_base > ONE) ? ONE : i_base;
        r_b     <= (i_blend > ONE) ? ONE : i_blend;
        r_mode1 <= i_mode;
    end

    // Stage 2: multiplier operands, the result of the adder modes, divider operands.
    logic         a_gt_half;
    logic [W-1:0] a_mh;
    logic [W-1:0] a_dbl;
    logic [W-1:0] a_ovl;
    logic [W-1:0] one_a;
    logic [W-1:0] one_b;
    logic [W:0]   sum_ab;
    logic [W:0]   t_half_a;
    logic [W:0]   b_ext;
    logic [W:0]   half_ext;

    assign a_gt_half = r_a > HALF;
    assign a_mh      = r_a - HALF;
    assign a_dbl     = {r_a[W-2:0], 1'b0};
    assign a_ovl     = ONE - {a_mh[W-2:0], 1'b0};
    assign one_a     = ONE - r_a;
    assign one_b     = ONE - r_b;
    assign sum_ab    = {1'b0, r_a} + {1'b0, r_b};
    assign t_half_a  = {1'b0, r_a} + {1'b0, HALF};
    assign b_ext     = {1'b0, r_b};
    assign half_ext  = {1'b0, HALF};

    t_ctl         n_ctl;
    logic [W-1:0] n_x;
    logic [W-1:0] n_y;
    logic [W-1:0] n_s;
    logic [W-1:0] n_num;
    logic [W-1:0] n_den;

    always_comb begin
        n_ctl      = '0;
        n_ctl.vld  = r_vld1;
        n_ctl.path = PATH_SIMPLE;
        n_x        = r_a;
        n_y        = r_b;
        n_s        = '0;
        n_num      = one_a;
        n_den      = r_b;
        case (t_mode'(r_mode1))
            MODE_NORMAL: begin
                n_s = r_b;
            end
            MODE_MULTIPLY: begin
                n_ctl.path = PATH_MULT;
            end
            MODE_SCREEN: begin
                n_ctl.path = PATH_MULT;
                n_ctl.inv  = 1'b1;
                n_x        = one_a;
                n_y        = one_b;
            end
            MODE_OVERLAY: begin
                n_ctl.path = PATH_MULT;
                if (a_gt_half) begin
                    n_ctl.inv = 1'b1;
                    n_x       = a_ovl;
                    n_y       = one_b;
                end else begin
                    n_x = a_dbl;
                end
            end
            MODE_OVERLAY_INV: begin
                n_ctl.path = PATH_MULT;
                if (a_gt_half) begin
                    n_ctl.inv = 1'b1;
                    n_x       = a_ovl;
                end else begin
                    n_x = a_dbl;
                    n_y = one_b;
                end
            end
            MODE_ADD: begin
                n_s = clamp_one(sum_ab);
            end
            MODE_GRAIN_EXTRACT: begin
                n_s = (t_half_a < b_ext) ? '0 : clamp_one(t_half_a - b_ext);
            end
            MODE_GRAIN_MERGE: begin
                n_s = (sum_ab < half_ext) ? '0 : clamp_one(sum_ab - half_ext);
            end
            MODE_SUBTRACT: begin
                n_s = (r_a < r_b) ? '0 : r_a - r_b;
            end
            MODE_DIFFERENCE: begin
                n_s = (r_a > r_b) ? r_a - r_b : r_b - r_a;
            end
            MODE_DARKEN: begin
                n_s = (r_a < r_b) ? r_a : r_b;
            end
            MODE_LIGHTEN: begin
                n_s = (r_a > r_b) ? r_a : r_b;
            end
            MODE_DODGE: begin
                // A full layer leaves no divisor; the result saturates.
                if (r_b == ONE) begin
                    n_s = ONE;
                end else begin
                    n_ctl.path = PATH_DIV;
                    n_num      = r_a;
                    n_den      = one_b;
                end
            end
            MODE_BURN: begin
                // An empty layer leaves no divisor; the result is black.
                if (r_b == '0) begin
                    n_s = '0;
                end else begin
                    n_ctl.path = PATH_DIV;
                    n_ctl.burn = 1'b1;
                end
            end
            default: begin
                n_s = '0;
            end
        endcase
    end

    t_ctl         r_ctl2;
    logic [W-1:0] r_x;
    logic [W-1:0] r_y;
    logic [W-1:0] r_s;
    logic [W-1:0] r_num;
    logic [W-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else begin
            r_ctl2 <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_s   <= n_s;
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_ctl    = r_ctl2;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_simple = r_s;
    assign o_num    = r_num;
    assign o_den    = r_den;

endmodule

FILE: design/blm_mul.sv
// Fixed-point multiply stage that also merges the product with the adder result.
`timescale 1ns / 1ps
module blm_mul
    import blm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    input  logic [FRAC_BITS:0]  i_x,
    input  logic [FRAC_BITS:0]  i_y,
    input  logic [FRAC_BITS:0]  i_simple,
    input  logic [FRAC_BITS:0]  i_num,
    input  logic [FRAC_BITS:0]  i_den,
    output t_ctl                o_ctl,
    output logic [FRAC_BITS:0]  o_res,
    output logic [FRAC_BITS:0]  o_num,
    output logic [FRAC_BITS:0]  o_den
);

    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [2*W-1:0] prod;
    logic [W-1:0]   p;
    logic [W-1:0]   mres;

    // Both operands are at most one, so the truncated product fits the value width.
    assign prod = (2*W)'(i_x) * (2*W)'(i_y);
    assign p    = prod[FRAC_BITS +: W];
    assign mres = i_ctl.inv ? ONE - p : p;

    t_ctl         r_ctl;
    logic [W-1:0] r_res;
    logic [W-1:0] r_num;
    logic [W-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= (i_ctl.path == PATH_MULT) ? mres : i_simple;
        r_num <= i_num;
        r_den <= i_den;
    end

    assign o_ctl = r_ctl;
    assign o_res = r_res;
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

FILE: design/blm_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient clamped to one.
`timescale 1ns / 1ps
`include "pixel_blend_mode_unit_defines.svh"
module blm_div
    import blm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = FRAC_BITS + 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [FRAC_BITS:0]  i_num,
    input  logic [FRAC_BITS:0]  i_den,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_vld,
    output logic [FRAC_BITS:0]  o_quo,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int W   = FRAC_BITS + 1;
    localparam int NST = W;
    localparam int LAT = NST + 1;
    localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic              r_vld  [0:NST];
    logic              r_ovf  [0:NST];
    logic [W-1:0]      r_q    [0:NST];
    logic [SIDE_W-1:0] r_side [0:NST];
    logic [W:0]        r_rem  [0:NST-1];
    logic [W-1:0]      r_den  [0:NST-1];

    // Entry stage. A numerator of at least twice the divisor gives a quotient of
    // two or more, which saturates; otherwise the quotient fits in W bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= {1'b0, i_num};
        r_den[0]  <= i_den;
        r_q[0]    <= '0;
        r_ovf[0]  <= {1'b0, i_num} >= {i_den, 1'b0};
        r_side[0] <= i_side;
    end

    for (genvar k = 1; k <= NST; k++) begin : g_stage
        logic ge;

        assign ge = r_rem[k-1] >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_q[k]    <= {r_q[k-1][W-2:0], ge};
            r_ovf[k]  <= r_ovf[k-1];
            r_side[k] <= r_side[k-1];
        end

        if (k < NST) begin : g_rem
            logic [W:0] diff;

            assign diff = ge ? r_rem[k-1] - {1'b0, r_den[k-1]} : r_rem[k-1];

            always_ff @(posedge i_clk) begin
                r_rem[k] <= {diff[W-1:0], 1'b0};
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_vld  = r_vld[NST];
    assign o_quo  = (r_ovf[NST] || (r_q[NST] > ONE)) ? ONE : r_q[NST];
    assign o_side = r_side[NST];

    `BLM_CHECK(a_div_latency, i_clk, i_rst_n, o_vld == $past(i_vld && i_rst_n, LAT), "bad valid")
    `BLM_CHECK_IMPL(a_div_range, i_clk, i_rst_n, o_vld, o_quo <= ONE, "quotient above one")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the pixel blend mode unit.
`timescale 1ns / 1ps
module tb_top;
    import blm_pkg::*;

    // The testbench runs the unit at its default width of 16 fraction bits, so
    // every channel value is 17 bits wide and 65536 stands for 1.0.
    localparam int     FRAC        = FRAC_BITS_DEF;
    localparam longint ONE         = longint'(1) << FRAC;
    localparam longint HALF        = ONE >> 1;
    localparam int     LATENCY     = FRAC + 6;
    localparam int     CYCLE_LIMIT = 200000;

    // The highest mode code selects no blend; the unit must return zero for it.
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

    // Values at the edges of the fixed-point range. They include the points on
    // either side of 0.5 (where overlay switches branch), 1.0 itself, and values
    // above 1.0 that the unit must saturate before blending.
    localparam int CORNERS [9] = '{0, 1, 32767, 32768, 32769, 65535, 65536, 65537, 131071};

    typedef struct packed {
        logic [FRAC:0] base;
        logic [FRAC:0] layer;
    } t_channel_pair;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_we        = 1'b0;
    logic [MODE_W-1:0]   i_cfg_wdata     = '0;
    logic                start           = 1'b0;
    logic                busy;
    logic [FRAC:0]       i_base_value    = '0;
    logic [FRAC:0]       i_blend_value   = '0;
    logic                o_strobe;
    logic [FRAC:0]       o_blended_value;

    // Transactions waiting to be driven, and blended values still owed by the unit.
    t_channel_pair       pending_pairs[$];
    logic [FRAC:0]       owed_blends[$];

    // Shadow of the mode register; it only changes while nothing is in flight.
    logic [MODE_W-1:0]   shadow_mode     = MODE_NORMAL;
    int                  send_idle_pct   = 0;
    int                  error_count     = 0;
    int                  cycle_count     = 0;

    pixel_blend_mode_unit #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_base_value   (i_base_value),
        .i_blend_value  (i_blend_value),
        .o_strobe       (o_strobe),
        .o_blended_value(o_blended_value)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Clamps a signed intermediate sum or difference to the range [0, 1.0].
    function automatic longint clamp_unit(input longint v);
        if (v < 0) begin
            return 0;
        end
        return (v > ONE) ? ONE : v;
    endfunction

    // Computes the blended value that the unit must return for one transaction.
    // Inputs above 1.0 are saturated first; products and quotients truncate.
    function automatic logic [FRAC:0] blend_of(input logic [MODE_W-1:0] mode,
                                               input logic [FRAC:0]     base_raw,
                                               input logic [FRAC:0]     layer_raw);
        longint a;
        longint b;
        longint q;
        longint r;
        a = (longint'(base_raw) > ONE) ? ONE : longint'(base_raw);
        b = (longint'(layer_raw) > ONE) ? ONE : longint'(layer_raw);
        case (mode)
            MODE_NORMAL: begin
                r = b;
            end
            MODE_MULTIPLY: begin
                r = (a * b) >> FRAC;
            end
            MODE_SCREEN: begin
                r = ONE - (((ONE - a) * (ONE - b)) >> FRAC);
            end
            MODE_OVERLAY: begin
                if (a > HALF) begin
                    r = ONE - (((ONE - 2 * (a - HALF)) * (ONE - b)) >> FRAC);
                end else begin
                    r = (2 * a * b) >> FRAC;
                end
            end
            MODE_OVERLAY_INV: begin
                if (a > HALF) begin
                    r = ONE - (((ONE - 2 * (a - HALF)) * b) >> FRAC);
                end else begin
                    r = (2 * a * (ONE - b)) >> FRAC;
                end
            end
            MODE_ADD: begin
                r = clamp_unit(a + b);
            end
            MODE_GRAIN_EXTRACT: begin
                r = clamp_unit(HALF + a - b);
            end
            MODE_GRAIN_MERGE: begin
                r = clamp_unit(a + b - HALF);
            end
            MODE_SUBTRACT: begin
                r = clamp_unit(a - b);
            end
            MODE_DIFFERENCE: begin
                r = (a > b) ? a - b : b - a;
            end
            MODE_DARKEN: begin
                r = (a < b) ? a : b;
            end
            MODE_LIGHTEN: begin
                r = (a > b) ? a : b;
            end
            MODE_DODGE: begin
                // A layer at full scale leaves no divisor; the result is 1.0.
                if (b >= ONE) begin
                    r = ONE;
                end else begin
                    q = (a << FRAC) / (ONE - b);
                    r = (q > ONE) ? ONE : q;
                end
            end
            MODE_BURN: begin
                // A layer of zero leaves no divisor; the result is zero.
                if (b == 0) begin
                    r = 0;
                end else begin
                    q = ((ONE - a) << FRAC) / b;
                    r = ONE - ((q > ONE) ? ONE : q);
                end
            end
            default: begin
                r = 0;
            end
        endcase
        return r[FRAC:0];
    endfunction

    // Draws a channel value: mostly uniform within [0, 1.0], often a corner value,
    // and sometimes any 17-bit pattern so that values above 1.0 and every bit occur.
    function automatic logic [FRAC:0] pick_channel();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25) begin
            return (FRAC + 1)'(CORNERS[$urandom_range(8)]);
        end else if (sel < 85) begin
            return (FRAC + 1)'($urandom_range(int'(ONE)));
        end
        return (FRAC + 1)'($urandom_range(131071));
    endfunction

    task automatic report_mismatch(input string what, input logic [FRAC:0] want,
                                   input logic [FRAC:0] got);
        $display("%0t mismatch: %s, expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    task automatic queue_pair(input logic [FRAC:0] base, input logic [FRAC:0] layer);
        t_channel_pair p;
        p.base  = base;
        p.layer = layer;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    // Waits until every queued transaction has been accepted and answered. The
    // check is made on the falling edge, when the driver's updates have settled.
    task automatic wait_for_drain();
        do begin
            @(negedge i_clk);
        end while (pending_pairs.size() != 0 || start || owed_blends.size() != 0);
    endtask

    // Writes the mode register. The unit is idle here, so the shadow copy can
    // change at once: no transaction can be accepted until the write is done.
    task automatic set_blend_mode(input logic [MODE_W-1:0] code);
        wait_for_drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        shadow_mode  = code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= MODE_W'($urandom);
    endtask

    // Driver. At each edge it first records the prediction for a transaction that
    // the unit took, then either holds the current transaction (start high while
    // busy), presents the next queued one, or idles with random data on the bus.
    always @(posedge i_clk) begin
        t_channel_pair next_pair;
        if (start === 1'b1 && busy === 1'b0) begin
            owed_blends.insert(owed_blends.size(),
                               blend_of(shadow_mode, i_base_value, i_blend_value));
        end
        if (!(start === 1'b1 && busy !== 1'b0)) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_pair      = pending_pairs.pop_front();
                start         <= 1'b1;
                i_base_value  <= next_pair.base;
                i_blend_value <= next_pair.layer;
            end else begin
                start         <= 1'b0;
                i_base_value  <= (FRAC + 1)'($urandom);
                i_blend_value <= (FRAC + 1)'($urandom);
            end
        end
    end

    // Monitor. A result is valid for one cycle only, so it is compared with the
    // oldest owed value at the edge that ends that cycle.
    always @(posedge i_clk) begin
        logic [FRAC:0] want;
        if (o_strobe === 1'b1) begin
            if (owed_blends.size() == 0) begin
                report_mismatch("result with no transaction owed", '0, o_blended_value);
            end else begin
                want = owed_blends.pop_front();
                if (o_blended_value !== want) begin
                    report_mismatch("blended_value", want, o_blended_value);
                end
            end
        end
    end

    // Watchdog: a hung unit or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** pixel_blend_mode_unit: FAILED **");
            $finish;
        end
    end

    // Stimulus sequence: reset, a directed pass over the corner cases and every
    // mode code, then random phases under three idling regimes and a final short burst.
    initial begin
        int offset;
        int count;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Before any write the mode must be normal. These transactions also check
        // that values above 1.0 are saturated on the layer input, which normal mode returns.
        queue_pair(17'h1FFFF, 17'h10001);
        queue_pair(17'h00000, 17'h1FFFF);
        queue_pair(17'(ONE), 17'(HALF));

        // One transaction per mode code, including the two unused codes, plus the
        // zero-divisor cases of dodge and burn.
        for (int m = 0; m < 16; m++) begin
            set_blend_mode(MODE_W'(m));
            queue_pair((FRAC + 1)'(CORNERS[m % 9]), (FRAC + 1)'(CORNERS[(m * 4 + 2) % 9]));
            if (MODE_W'(m) == MODE_DODGE) begin
                queue_pair(17'(HALF), 17'(ONE));
            end
            if (MODE_W'(m) == MODE_BURN) begin
                queue_pair(17'(HALF), 17'h00000);
            end
        end

        // Random part: every mode code once per idling regime, starting at a
        // random code so that the write order differs between regimes.
        for (int regime = 0; regime < 3; regime++) begin
            send_idle_pct = (regime == 0) ? 17 : (regime == 1) ? 73 : 0;
            offset        = $urandom_range(15);
            for (int k = 0; k < 16; k++) begin
                set_blend_mode(MODE_W'(k + offset));
                count = $urandom_range(43, 30);
                for (int n = 0; n < count; n++) begin
                    queue_pair(pick_channel(), pick_channel());
                end
            end
        end

        // Leave the register at the highest unused code with a final short burst.
        set_blend_mode(MODE_UNUSED_HI);
        for (int n = 0; n < 8; n++) begin
            queue_pair(pick_channel(), pick_channel());
        end

        wait_for_drain();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (error_count == 0 && owed_blends.size() == 0) begin
            $display("** pixel_blend_mode_unit: PASSED **");
        end else begin
            $display("** pixel_blend_mode_unit: FAILED **");
        end
        $finish;
    end

endmodule
